// File: rtl/fcrl_pkg.sv
`timescale 1ns / 1ps

package fcrl_pkg;

  // Default size of the slot region
  localparam int unsigned MAX_SLOTS_DEF = 64;

  // Field widths
  localparam int unsigned HDR_W      = 16;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SRCH_W     = 8;   // signed search bounds

  localparam logic [HDR_W-1:0] ERASED_HDR = 16'hFFFF;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_FIND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_PGERR    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;

  localparam logic [HDR_W-1:0] RECORD_SIZE_RST  = 16'd16;
  localparam logic [IDX_W-1:0] SLOTS_IN_USE_RST = 7'd64;

  // Controller to datapath
  typedef struct packed {
    logic take;          // latch the input beat
    logic srch_init;     // l = 0, r = n - 2
    logic srch_read;     // read mid and mid + 1
    logic srch_step;     // narrow the search window
    logic res_found;
    logic res_notfound;
    logic res_none;
    logic sweep_clr;
    logic sweep_step;    // erase one slot
    logic st_read;       // read the store target
    logic st_fresh;      // store into slot 0 after an erase
    logic st_commit;     // store into the next slot
    logic ld_write;      // preset one header
    logic out_load;      // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              need_erase;
    logic              sweep_last;
    logic              srch_empty;
    logic              srch_hit;
    logic              out_busy;
  } stat_t;

endpackage

// File: rtl/fcrl_ram.sv
`timescale 1ns / 1ps

module fcrl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // One write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/fcrl_ctrl.sv
`timescale 1ns / 1ps

module fcrl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fcrl_pkg::stat_t stat_i,
  output fcrl_pkg::cmd_t  cmd_o
);
  import fcrl_pkg::*;

  localparam logic [3:0] S_CLEAR       = 4'd0;
  localparam logic [3:0] S_IDLE        = 4'd1;
  localparam logic [3:0] S_DECODE      = 4'd2;
  localparam logic [3:0] S_FIND_CHK    = 4'd3;
  localparam logic [3:0] S_FIND_EVAL   = 4'd4;
  localparam logic [3:0] S_ERASE       = 4'd5;
  localparam logic [3:0] S_STORE_FRESH = 4'd6;
  localparam logic [3:0] S_STORE_WR    = 4'd7;
  localparam logic [3:0] S_DONE        = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.kind)
          KIND_FIND: begin
            cmd_o.srch_init = 1'b1;
            state_d         = S_FIND_CHK;
          end
          KIND_STORE: begin
            if (stat_i.need_erase) begin
              cmd_o.sweep_clr = 1'b1;
              state_d         = S_ERASE;
            end else begin
              cmd_o.st_read = 1'b1;
              state_d       = S_STORE_WR;
            end
          end
          KIND_LOAD: begin
            cmd_o.ld_write = 1'b1;
            state_d        = S_DONE;
          end
          default: begin
            cmd_o.res_none = 1'b1;
            state_d        = S_DONE;
          end
        endcase
      end
      S_FIND_CHK: begin
        if (stat_i.srch_empty) begin
          cmd_o.res_notfound = 1'b1;
          state_d            = S_DONE;
        end else begin
          cmd_o.srch_read = 1'b1;
          state_d         = S_FIND_EVAL;
        end
      end
      S_FIND_EVAL: begin
        if (stat_i.srch_hit) begin
          cmd_o.res_found = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.srch_step = 1'b1;
          state_d         = S_FIND_CHK;
        end
      end
      S_ERASE: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_STORE_FRESH;
        end
      end
      S_STORE_FRESH: begin
        cmd_o.st_fresh = 1'b1;
        state_d        = S_DONE;
      end
      S_STORE_WR: begin
        cmd_o.st_commit = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/fcrl_dp.sv
`timescale 1ns / 1ps

module fcrl_dp #(
  parameter int unsigned MAX_SLOTS = fcrl_pkg::MAX_SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fcrl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fcrl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [fcrl_pkg::KIND_W-1:0]         kind_i,
  input  logic [fcrl_pkg::SLOT_W-1:0]         slot_index_i,
  input  logic [fcrl_pkg::HDR_W-1:0]          header_value_i,
  input  fcrl_pkg::cmd_t                      cmd_i,
  output fcrl_pkg::stat_t                     stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fcrl_pkg::STAT_W-1:0]         status_o,
  output logic [fcrl_pkg::SLOT_W-1:0]         slot_o,
  output logic                                erased_o
);
  import fcrl_pkg::*;

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

  // Configuration
  logic [HDR_W-1:0] rec_size_q;
  logic [IDX_W-1:0] slots_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_size_q <= RECORD_SIZE_RST;
      slots_q    <= SLOTS_IN_USE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RECORD_SIZE:  rec_size_q <= cfg_wdata_i[HDR_W-1:0];
        CFG_SLOTS_IN_USE: slots_q    <= cfg_wdata_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective slot count
  logic [IDX_W-1:0] n_eff;
  always_comb begin
    if (int'(slots_q) > int'(MAX_SLOTS)) begin
      n_eff = IDX_W'(MAX_SLOTS);
    end else begin
      n_eff = slots_q;
    end
  end

  // Latched input beat
  logic [KIND_W-1:0] kind_q;
  logic [SLOT_W-1:0] sidx_q;
  logic [HDR_W-1:0]  hval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q <= kind_i;
      sidx_q <= slot_index_i;
      hval_q <= header_value_i;
    end
  end

  // Current record pointer
  logic             cur_valid_q, cur_valid_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] tgt;

  assign tgt = cur_q + IDX_W'(1);

  // Search window and erase sweep
  logic signed [SRCH_W-1:0] l_q, l_d, r_q, r_d, mid_q, mid_c;
  logic [AW-1:0]            sweep_q, sweep_d;

  assign mid_c = l_q + ((r_q - l_q) >>> 1);

  // Header store
  logic             we;
  logic [AW-1:0]    waddr;
  logic [HDR_W-1:0] wdata;
  logic [AW-1:0]    raddr_a, raddr_b;
  logic [HDR_W-1:0] rdata_a, rdata_b;

  assign raddr_a = cmd_i.st_read ? AW'(tgt) : AW'($unsigned(mid_c));
  assign raddr_b = AW'($unsigned(mid_c + SRCH_W'(1)));

  always_comb begin
    we    = 1'b0;
    waddr = sweep_q;
    wdata = ERASED_HDR;
    if (cmd_i.sweep_step) begin
      we = 1'b1;
    end else if (cmd_i.st_fresh) begin
      we    = 1'b1;
      waddr = '0;
      wdata = rec_size_q;
    end else if (cmd_i.st_commit) begin
      we    = (rdata_a == ERASED_HDR);
      waddr = AW'(tgt);
      wdata = rec_size_q;
    end else if (cmd_i.ld_write) begin
      we    = (int'(sidx_q) < int'(MAX_SLOTS));
      waddr = AW'(sidx_q);
      wdata = hval_q;
    end
  end

  fcrl_ram #(
    .WIDTH(HDR_W),
    .DEPTH(MAX_SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // Pending result
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic              res_erased_q, res_erased_d;

  // Search, pointer and result updates
  always_comb begin
    l_d          = l_q;
    r_d          = r_q;
    sweep_d      = sweep_q;
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_erased_d = res_erased_q;

    if (cmd_i.srch_init) begin
      l_d = '0;
      r_d = $signed({1'b0, n_eff}) - SRCH_W'(2);
    end
    if (cmd_i.srch_step) begin
      if (rdata_a == rec_size_q) begin
        l_d = mid_q + SRCH_W'(1);
      end else begin
        r_d = mid_q - SRCH_W'(1);
      end
    end
    if (cmd_i.sweep_clr) begin
      sweep_d = '0;
    end else if (cmd_i.sweep_step) begin
      sweep_d = sweep_q + AW'(1);
    end

    if (cmd_i.res_found) begin
      cur_valid_d  = 1'b1;
      cur_d        = IDX_W'($unsigned(mid_q));
      res_status_d = ST_OK;
      res_slot_d   = SLOT_W'($unsigned(mid_q));
      res_erased_d = 1'b0;
    end
    if (cmd_i.res_notfound || cmd_i.res_none) begin
      res_status_d = cmd_i.res_notfound ? ST_NOTFOUND : ST_OK;
      res_slot_d   = '0;
      res_erased_d = 1'b0;
    end
    if (cmd_i.st_fresh) begin
      cur_valid_d  = 1'b1;
      cur_d        = '0;
      res_status_d = ST_OK;
      res_slot_d   = '0;
      res_erased_d = 1'b1;
    end
    if (cmd_i.st_commit) begin
      cur_valid_d  = 1'b1;
      cur_d        = tgt;
      res_status_d = (rdata_a == ERASED_HDR) ? ST_OK : ST_PGERR;
      res_slot_d   = SLOT_W'(tgt);
      res_erased_d = 1'b0;
    end
    if (cmd_i.ld_write) begin
      res_status_d = ST_OK;
      res_slot_d   = sidx_q;
      res_erased_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
      sweep_q     <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cur_q       <= cur_d;
      sweep_q     <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q          <= l_d;
    r_q          <= r_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_erased_q <= res_erased_d;
    if (cmd_i.srch_read) begin
      mid_q <= mid_c;
    end
  end

  // Output register
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_erased_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_erased_q <= res_erased_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign erased_o    = out_erased_q;

  // Status back to the controller
  always_comb begin
    stat_o.kind       = kind_q;
    stat_o.need_erase = !cur_valid_q ||
                        ($signed({2'b00, cur_q}) > ($signed({2'b00, n_eff}) - 9'sd3));
    stat_o.sweep_last = (sweep_q == LAST_ADDR);
    stat_o.srch_empty = (r_q < l_q);
    stat_o.srch_hit   = (rdata_a == rec_size_q) && (rdata_b == ERASED_HDR);
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

endmodule

// File: rtl/flash_config_record_log_core.sv
`timescale 1ns / 1ps

// Header log of an emulated EEPROM in flash: one 16-bit header per slot.
// Input channel (in_valid_i / in_ready_o) carries one command beat: kind_i
// selects find (binary search for the last valid record), store (append in
// the next slot, erasing the region first when needed) or load (preset one
// header). Output channel (out_valid_o / out_ready_i) returns exactly one
// beat per command: status_o, slot_o, erased_o.
// Registers record_size and slots_in_use are written through cfg_we_i,
// cfg_index_i and cfg_wdata_i; the user must write them only while no
// command is in flight, as the block does not enforce this. Commands are
// handled one at a time; a new beat is taken as soon as the previous result
// sits in the output register, even if it is not yet taken. A find
// alternates a check and an evaluate state per probe; each probe is one
// two-port read of the header RAM. A store with erase first sweeps every slot.
// Reset clears the pointer and registers, then sweeps the header RAM to the
// erased value with in_ready_o low.
// When the receiver stalls, the result holds and the next finished result
// waits inside the block until the output register frees up.
module flash_config_record_log_core #(
  parameter int unsigned MAX_SLOTS = fcrl_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fcrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fcrl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fcrl_pkg::KIND_W-1:0]     kind_i,
  input  logic [fcrl_pkg::SLOT_W-1:0]     slot_index_i,
  input  logic [fcrl_pkg::HDR_W-1:0]      header_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fcrl_pkg::STAT_W-1:0]     status_o,
  output logic [fcrl_pkg::SLOT_W-1:0]     slot_o,
  output logic                            erased_o
);
  import fcrl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fcrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fcrl_dp #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (kind_i),
    .slot_index_i   (slot_index_i),
    .header_value_i (header_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .erased_o       (erased_o)
  );

endmodule

// File: rtl/fcrl_checker.sv
`timescale 1ns / 1ps

module fcrl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [fcrl_pkg::STAT_W-1:0] status_i,
  input logic [fcrl_pkg::SLOT_W-1:0] slot_i,
  input logic                        erased_i
);
  import fcrl_pkg::*;

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(slot_i) && $stable(erased_i))
    else $error("stalled result beat changed");

  // One command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on back-to-back cycles");

  // An erasing store always lands in slot 0 without error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && erased_i |-> status_i == ST_OK && slot_i == '0)
    else $error("erasing store reported wrong slot or status");

  // A failed find reports slot 0 and no erase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_NOTFOUND |-> slot_i == '0 && !erased_i)
    else $error("not-found result carries slot or erase flag");

endmodule

bind flash_config_record_log_core fcrl_checker u_fcrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_i    (status_o),
  .slot_i      (slot_o),
  .erased_i    (erased_o)
);

// File: verif/fcrl_reply_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the record log, keeps its
// own copy of the slot headers and the record pointer, and checks every reply
// beat against the oldest predicted reply.
module fcrl_reply_checker #(
  parameter int unsigned MAX_SLOTS = fcrl_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fcrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fcrl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [fcrl_pkg::KIND_W-1:0]     kind_i,
  input  logic [fcrl_pkg::SLOT_W-1:0]     slot_index_i,
  input  logic [fcrl_pkg::HDR_W-1:0]      header_value_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [fcrl_pkg::STAT_W-1:0]     status_i,
  input  logic [fcrl_pkg::SLOT_W-1:0]     slot_i,
  input  logic                            erased_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import fcrl_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              erased;
  } reply_t;

  // Model state: headers, record pointer, registers
  logic [HDR_W-1:0] hdr_mem [MAX_SLOTS];
  logic             ptr_valid;
  logic [IDX_W-1:0] ptr_slot;
  logic [HDR_W-1:0] rec_size;
  logic [IDX_W-1:0] slot_count;

  reply_t reply_q [$];
  reply_t want_r;
  reply_t new_r;
  int     n_fail = 0;

  assign fail_count_o = n_fail;

  task automatic erase_headers();
    foreach (hdr_mem[i]) hdr_mem[i] = ERASED_HDR;
  endtask

  // One command against the header model; updates the model state
  task automatic predict_log_op(input logic [KIND_W-1:0] kind,
                                input logic [SLOT_W-1:0] sidx,
                                input logic [HDR_W-1:0] hval,
                                output reply_t r);
    int n;
    int lo;
    int hi;
    int mid;
    int hit;
    int tgt;
    r = '0;
    n = (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
    case (kind)
      KIND_FIND: begin
        // binary search for the last record whose successor is still erased
        lo  = 0;
        hi  = n - 2;
        hit = -1;
        while (hit < 0 && hi >= lo) begin
          mid = lo + (hi - lo) / 2;
          if (hdr_mem[mid] == rec_size) begin
            if (hdr_mem[mid+1] == ERASED_HDR) hit = mid;
            else lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          ptr_valid = 1'b1;
          ptr_slot  = IDX_W'(hit);
          r.slot    = SLOT_W'(hit);
        end
      end
      KIND_STORE: begin
        // no pointer or log near full: wipe the region and restart at 0
        if (!ptr_valid || int'(ptr_slot) > n - 3) begin
          erase_headers();
          r.erased = 1'b1;
          tgt      = 0;
        end else begin
          tgt = int'(ptr_slot) + 1;
        end
        ptr_valid = 1'b1;
        ptr_slot  = IDX_W'(tgt);
        r.slot    = SLOT_W'(tgt);
        if (tgt >= MAX_SLOTS || hdr_mem[tgt] != ERASED_HDR) r.status = ST_PGERR;
        else hdr_mem[tgt] = rec_size;
      end
      KIND_LOAD: begin
        if (sidx < MAX_SLOTS) hdr_mem[sidx] = hval;
        r.slot = sidx;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("reply field %s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_headers();
      ptr_valid  = 1'b0;
      ptr_slot   = '0;
      rec_size   = RECORD_SIZE_RST;
      slot_count = SLOTS_IN_USE_RST;
      reply_q.delete();
      pending_o <= 0;
    end else begin
      // reply beat against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          $error("reply beat with nothing pending: status %0d slot %0d erased %0d",
                 status_i, slot_i, erased_i);
          n_fail++;
        end else begin
          want_r = reply_q.pop_front();
          check_field("status", want_r.status, status_i);
          check_field("slot", want_r.slot, slot_i);
          check_field("erased", want_r.erased, erased_i);
        end
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RECORD_SIZE:  rec_size = cfg_wdata_i[HDR_W-1:0];
          CFG_SLOTS_IN_USE: slot_count = cfg_wdata_i[IDX_W-1:0];
          default: ;
        endcase
      end
      // command beat
      if (in_valid_i && in_ready_i) begin
        predict_log_op(kind_i, slot_index_i, header_value_i, new_r);
        reply_q.push_back(new_r);
      end
      pending_o <= reply_q.size();
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import fcrl_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 120;  // longer than a store with erase
  localparam int N_PHASES       = 10;
  localparam int PHASE_ITEMS    = 40;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [KIND_W-1:0]     kind_i         = '0;
  logic [SLOT_W-1:0]     slot_index_i   = '0;
  logic [HDR_W-1:0]      header_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [STAT_W-1:0]     status_o;
  logic [SLOT_W-1:0]     slot_o;
  logic                  erased_o;

  int n_fail;
  int n_pending;
  int n_sent       = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  // register values as last written, to shape the stimulus
  logic [HDR_W-1:0] cur_rs  = RECORD_SIZE_RST;
  logic [IDX_W-1:0] cur_siu = SLOTS_IN_USE_RST;

  flash_config_record_log_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .slot_index_i   (slot_index_i),
    .header_value_i (header_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .erased_o       (erased_o)
  );

  fcrl_reply_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .slot_index_i   (slot_index_i),
    .header_value_i (header_value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .slot_i         (slot_o),
    .erased_i       (erased_o),
    .fail_count_o   (n_fail),
    .pending_o      (n_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one command beat; valid stays high into the next beat when there is no gap
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] sidx,
                         input logic [HDR_W-1:0] hval);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    slot_index_i   <= sidx;
    header_value_i <= hval;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // hold off until every pending reply has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    if (idx == CFG_RECORD_SIZE) cur_rs = data[HDR_W-1:0];
    if (idx == CFG_SLOTS_IN_USE) cur_siu = data[IDX_W-1:0];
    @(posedge clk_i);
    if (last) cfg_we_i <= 1'b0;
  endtask

  function automatic int eff_slots();
    return (cur_siu > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(cur_siu);
  endfunction

  function automatic logic [HDR_W-1:0] pick_header();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return cur_rs;
    if (sel < 8) return ERASED_HDR;
    return HDR_W'($urandom);
  endfunction

  // lay down a log of valid records then erased slots, then find and append
  task automatic preset_log();
    int n;
    int len;
    int last_rec;
    int i;
    logic [HDR_W-1:0] hv;
    n   = eff_slots();
    len = (n > 12 && $urandom_range(2) != 0) ? 12 : n;
    if (len == 0) len = 1;
    last_rec = $urandom_range(len - 1);
    for (i = 0; i < len; i++) begin
      hv = (i <= last_rec) ? cur_rs : ERASED_HDR;
      if ($urandom_range(9) == 0) hv = HDR_W'($urandom);  // broken log
      send_op(KIND_LOAD, SLOT_W'(i), hv);
    end
    send_op(KIND_FIND, SLOT_W'($urandom), HDR_W'($urandom));
    repeat ($urandom_range(1, 4)) send_op(KIND_STORE, SLOT_W'($urandom), HDR_W'($urandom));
    if ($urandom_range(1)) send_op(KIND_FIND, SLOT_W'($urandom), HDR_W'($urandom));
  endtask

  task automatic random_phase(input int quota);
    int target;
    int sel;
    int n;
    logic [SLOT_W-1:0] sidx;
    target = n_sent + quota;
    while (n_sent < target) begin
      sel = $urandom_range(99);
      n   = eff_slots();
      if (sel < 25) begin
        preset_log();
      end else if (sel < 50) begin
        send_op(KIND_STORE, SLOT_W'($urandom), HDR_W'($urandom));
      end else if (sel < 72) begin
        send_op(KIND_FIND, SLOT_W'($urandom), HDR_W'($urandom));
      end else if (sel < 94) begin
        sidx = (n > 0 && $urandom_range(9) < 7) ? SLOT_W'($urandom_range(n - 1))
                                                : SLOT_W'($urandom);
        send_op(KIND_LOAD, sidx, pick_header());
      end else if (sel < 97) begin
        send_op(KIND_UNUSED, SLOT_W'($urandom), HDR_W'($urandom));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    int ph;
    logic [HDR_W-1:0] rs_v;
    logic [IDX_W-1:0] siu_v;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty log, append, find, program error, field extremes
    send_op(KIND_FIND, '0, '0);
    send_op(KIND_STORE, '1, '1);
    send_op(KIND_STORE, '0, '0);
    send_op(KIND_FIND, '1, '1);
    send_op(KIND_LOAD, 6'd2, 16'h0000);
    send_op(KIND_STORE, '0, '0);
    send_op(KIND_LOAD, 6'd63, ERASED_HDR);
    send_op(KIND_LOAD, 6'd0, 16'hFFFE);
    send_op(KIND_LOAD, 6'd62, cur_rs);
    send_op(KIND_UNUSED, '1, '1);
    send_op(KIND_FIND, '0, '0);
    drain();

    // unused register index, then tiny regions where every store erases
    cfg_write(CFG_SPARE, 16'h1234, 1'b0);
    cfg_write(CFG_SLOTS_IN_USE, 16'd1, 1'b1);
    send_op(KIND_FIND, '0, '0);
    send_op(KIND_STORE, '0, '0);
    drain();
    cfg_write(CFG_SLOTS_IN_USE, 16'd2, 1'b1);
    send_op(KIND_STORE, '0, '0);
    send_op(KIND_STORE, '0, '0);
    send_op(KIND_FIND, '0, '0);
    drain();

    // log fills up and wraps with an erase
    cfg_write(CFG_SLOTS_IN_USE, 16'd4, 1'b1);
    repeat (4) send_op(KIND_STORE, '0, '0);
    send_op(KIND_FIND, '0, '0);
    drain();
    cfg_write(CFG_SLOTS_IN_USE, 16'd0, 1'b1);
    send_op(KIND_FIND, '0, '0);
    send_op(KIND_STORE, '0, '0);
    drain();

    // random phases over register settings and idle patterns
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin rs_v = 16'd16;  siu_v = 7'd64; end
        1: begin rs_v = 16'hFFFE; siu_v = 7'd3; end
        2: begin rs_v = 16'd1;   siu_v = 7'd64; end
        3: begin rs_v = HDR_W'($urandom); siu_v = IDX_W'($urandom_range(3, 64)); end
        4: begin rs_v = 16'd0;   siu_v = 7'd2; end
        5: begin rs_v = 16'hFFFF; siu_v = 7'd127; end
        6: begin rs_v = HDR_W'($urandom); siu_v = IDX_W'($urandom_range(5, 12)); end
        7: begin rs_v = HDR_W'($urandom); siu_v = IDX_W'($urandom_range(65, 127)); end
        8: begin rs_v = HDR_W'($urandom); siu_v = IDX_W'($urandom_range(3, 8)); end
        default: begin rs_v = 16'd16; siu_v = 7'd64; end
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      cfg_write(CFG_RECORD_SIZE, CFG_DATA_W'(rs_v), 1'b0);
      cfg_write(CFG_SLOTS_IN_USE, CFG_DATA_W'(siu_v), 1'b1);
      random_phase(PHASE_ITEMS);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
